[rtl/nprs_pkg.sv]
`timescale 1ns / 1ps

package nprs_pkg;

  localparam int CURSOR_W = 28;
  localparam int COUNT_W  = 24;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int ACT_W    = 2;

  // input actions
  localparam logic [ACT_W-1:0] ACT_START  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STATUS = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DATA   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SELECT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CMD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADDR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DATA   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd4;

  // flash commands
  localparam logic [BYTE_W-1:0] CMD_READ    = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_CONFIRM = 8'h30;

  // what follows the select or data result of a job
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_BURST
  } tail_t;

  typedef struct packed {
    logic                sel;
    logic                dat;
    logic [BYTE_W-1:0]   dbyte;
    logic [COUNT_W-1:0]  didx;
    tail_t               tail;
    logic [CURSOR_W-1:0] cursor;
  } job_t;

endpackage

[rtl/nprs_front.sv]
`timescale 1ns / 1ps

module nprs_front
  import nprs_pkg::*;
#(
  parameter int PAGE_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [CURSOR_W-1:0] in_start_address,
  input  logic [COUNT_W-1:0]  in_length,
  input  logic                in_ready_req,
  input  logic [BYTE_W-1:0]   in_flash_byte,
  input  logic                q_full,
  output logic                push,
  output job_t                job
);

  // page size is a power of two, so column and row are bit fields of the cursor
  localparam int COL_W = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DATA
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic [COUNT_W-1:0]  done_r, done_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [CURSOR_W-1:0] cur_inc;
  logic [COUNT_W-1:0]  done_inc;
  logic                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign cur_inc  = CURSOR_W'(cursor_r + 1'b1);
  assign done_inc = COUNT_W'(done_r + 1'b1);

  always_comb begin
    phase_nxt  = phase_r;
    cursor_nxt = cursor_r;
    done_nxt   = done_r;
    total_nxt  = total_r;
    push       = 1'b0;
    job.sel    = 1'b0;
    job.dat    = 1'b0;
    job.dbyte  = in_flash_byte;
    job.didx   = done_r;
    job.tail   = TAIL_NONE;
    job.cursor = cursor_r;
    if (accept) begin
      unique case (in_action)
        ACT_START: begin
          if (phase_r == PH_IDLE) begin
            cursor_nxt = in_start_address;
            total_nxt  = in_length;
            done_nxt   = '0;
            push       = 1'b1;
            job.sel    = 1'b1;
            job.cursor = in_start_address;
            if (in_length == '0) begin
              job.tail = TAIL_DONE;
            end else begin
              job.tail  = TAIL_BURST;
              phase_nxt = PH_WAIT;
            end
          end
        end
        ACT_STATUS: begin
          if (phase_r == PH_WAIT && in_ready_req) phase_nxt = PH_DATA;
        end
        ACT_DATA: begin
          if (phase_r == PH_DATA) begin
            push       = 1'b1;
            job.dat    = 1'b1;
            done_nxt   = done_inc;
            cursor_nxt = cur_inc;
            job.cursor = cur_inc;
            if (done_inc == total_r) begin
              job.tail  = TAIL_DONE;
              phase_nxt = PH_IDLE;
            end else if (cur_inc[COL_W-1:0] == '0) begin
              // next byte starts a new page: reissue the read sequence
              job.tail  = TAIL_BURST;
              phase_nxt = PH_WAIT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cursor_r <= '0;
      done_r   <= '0;
      total_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cursor_r <= cursor_nxt;
      done_r   <= done_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

[rtl/nprs_queue.sv]
`timescale 1ns / 1ps

module nprs_queue
  import nprs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = entries_r[rd_r];

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_r + 1'b1);
    if (do_pop) rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_r + 1'b1);
    if (do_push && !do_pop) count_nxt = CNT_W'(count_r + 1'b1);
    else if (do_pop && !do_push) count_nxt = CNT_W'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_r] <= wr_job;
  end

endmodule

[rtl/nprs_back.sv]
`timescale 1ns / 1ps

module nprs_back
  import nprs_pkg::*;
#(
  parameter int PAGE_BYTES = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  job_t               job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [BYTE_W-1:0]  out_value,
  output logic [COUNT_W-1:0] out_dest_index,
  output logic               out_last
);

  localparam int COL_W = $clog2(PAGE_BYTES);

  logic [2:0]          step_r, step_nxt;
  logic                valid_r, valid_nxt;
  logic [KIND_W-1:0]   kind_r;
  logic [BYTE_W-1:0]   value_r;
  logic [COUNT_W-1:0]  idx_r;
  logic                last_r;

  logic [KIND_W-1:0]   kind_c;
  logic [BYTE_W-1:0]   value_c;
  logic [COUNT_W-1:0]  idx_c;
  logic [1:0]          pre_n;
  logic [3:0]          n_items;
  logic [2:0]          t;
  logic                is_last;
  logic                load;
  logic [COL_W-1:0]    col;
  logic [CURSOR_W-1:0] row;

  assign col     = job.cursor[COL_W-1:0];
  assign row     = job.cursor >> COL_W;
  assign pre_n   = 2'(job.sel) + 2'(job.dat);
  assign n_items = 4'(pre_n) + ((job.tail == TAIL_DONE)  ? 4'd1 :
                                (job.tail == TAIL_BURST) ? 4'd7 : 4'd0);
  assign t       = 3'(step_r - 3'(pre_n));
  assign is_last = (4'(step_r) == 4'(n_items - 4'd1));
  assign load    = job_valid && (!valid_r || out_ready);
  assign pop     = load && is_last;

  // pick the result at the current step of the job at the queue head
  always_comb begin
    kind_c  = KIND_CMD;
    value_c = '0;
    idx_c   = '0;
    if (3'(step_r) < 3'(pre_n)) begin
      if (step_r == '0 && job.sel) begin
        kind_c = KIND_SELECT;
      end else begin
        kind_c  = KIND_DATA;
        value_c = job.dbyte;
        idx_c   = job.didx;
      end
    end else if (job.tail == TAIL_DONE) begin
      kind_c = KIND_DONE;
    end else begin
      unique case (t)
        3'd0: begin kind_c = KIND_CMD;  value_c = CMD_READ; end
        3'd1: begin kind_c = KIND_ADDR; value_c = col[7:0]; end
        3'd2: begin kind_c = KIND_ADDR; value_c = 8'(col >> 8); end
        3'd3: begin kind_c = KIND_ADDR; value_c = row[7:0]; end
        3'd4: begin kind_c = KIND_ADDR; value_c = row[15:8]; end
        3'd5: begin kind_c = KIND_ADDR; value_c = {7'd0, row[16]}; end
        default: begin kind_c = KIND_CMD; value_c = CMD_CONFIRM; end
      endcase
    end
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = is_last ? '0 : 3'(step_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_c;
      value_r <= value_c;
      idx_r   <= idx_c;
      last_r  <= is_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_value      = value_r;
  assign out_dest_index = idx_r;
  assign out_last       = last_r;

endmodule

[rtl/nand_page_read_sequencer_top.sv]
`timescale 1ns / 1ps
// with nothing queued ahead, an accepted request goes into the queue, then the output register
// throughput: one result per cycle unless out_ready stalls; a data byte in a page yields one
// result, the last byte two, a start or page change eight (select or data plus 7-byte burst)
// and a zero-length start two; the front takes a request every cycle while the queue has room
// reset (synchronous, active low) returns to idle, empties the queue and drops out_valid
module nand_page_read_sequencer_top
  import nprs_pkg::*;
#(
  parameter int PAGE_BYTES  = 2048,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [CURSOR_W-1:0] in_start_address,
  input  logic [COUNT_W-1:0]  in_length,
  input  logic                in_ready_req,
  input  logic [BYTE_W-1:0]   in_flash_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [BYTE_W-1:0]   out_value,
  output logic [COUNT_W-1:0]  out_dest_index,
  output logic                out_last
);

  job_t wr_job, rd_job;
  logic push, pop, q_empty, q_full;

  nprs_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_start_address(in_start_address),
    .in_length       (in_length),
    .in_ready_req    (in_ready_req),
    .in_flash_byte   (in_flash_byte),
    .q_full          (q_full),
    .push            (push),
    .job             (wr_job)
  );

  nprs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_job(wr_job),
    .pop   (pop),
    .rd_job(rd_job),
    .empty (q_empty),
    .full  (q_full)
  );

  nprs_back #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (!q_empty),
    .job           (rd_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_dest_index(out_dest_index),
    .out_last      (out_last)
  );

endmodule

[rtl/nprs_checker.sv]
`timescale 1ns / 1ps

module nprs_checker
  import nprs_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   out_kind,
  input logic [BYTE_W-1:0]   out_value,
  input logic [COUNT_W-1:0]  out_dest_index,
  input logic                out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_dest_index) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only data results carry a destination index
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_dest_index == '0)
    else $error("index on a non-data result");

  // select always starts a request with more to follow
  a_select_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SELECT |-> !out_last && out_value == '0)
    else $error("select closed a request");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last)
    else $error("done not marked last");

endmodule

bind nand_page_read_sequencer_top nprs_checker u_nprs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_value     (out_value),
  .out_dest_index(out_dest_index),
  .out_last      (out_last)
);

[test/nand_page_read_sequencer_top_test.sv]
`timescale 1ns / 1ps

module nand_page_read_sequencer_top_test;
  import nprs_pkg::*;

  localparam int PAGE = 2048;
  localparam int STALL_LIMIT = 2000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DATA
  } read_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] dest_index;
    logic               last;
  } read_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    in_action;
  logic [CURSOR_W-1:0] in_start_address;
  logic [COUNT_W-1:0]  in_length;
  logic                in_ready_req;
  logic [BYTE_W-1:0]   in_flash_byte;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_value;
  logic [COUNT_W-1:0]  out_dest_index;
  logic                out_last;

  // sequencer state as the testbench sees it
  read_phase_t         rd_phase;
  logic [CURSOR_W-1:0] rd_cursor;
  logic [COUNT_W-1:0]  rd_done;
  logic [COUNT_W-1:0]  rd_total;
  int                  rd_column;

  read_result_t pending_results[$];
  read_result_t head_result;
  int           fail_count;
  int           useful_requests;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_len;
  int           hold_tag;
  int           hold_tag_seen;
  int           hold_left;
  int           quiet_cycles;

  nand_page_read_sequencer_top #(
    .PAGE_BYTES(PAGE)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_start_address(in_start_address),
    .in_length       (in_length),
    .in_ready_req    (in_ready_req),
    .in_flash_byte   (in_flash_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_dest_index  (out_dest_index),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [CURSOR_W-1:0] rand_addr();
    return CURSOR_W'($urandom);
  endfunction

  function automatic logic [COUNT_W-1:0] rand_len();
    return COUNT_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic read_result_t make_result(input logic [KIND_W-1:0] k,
                                               input logic [BYTE_W-1:0] v,
                                               input logic [COUNT_W-1:0] idx);
    read_result_t r;
    r.kind = k;
    r.value = v;
    r.dest_index = idx;
    r.last = 1'b0;
    return r;
  endfunction

  // read command, five address bytes, confirm command for the current cursor
  task automatic push_address_burst();
    int col;
    int row;
    logic [BYTE_W-1:0] col_hi_mask;
    col = rd_cursor % PAGE;
    row = rd_cursor / PAGE;
    col_hi_mask = BYTE_W'(((PAGE - 1) >> 8) & 8'hFF);
    pending_results.push_back(make_result(KIND_CMD, CMD_READ, '0));
    pending_results.push_back(make_result(KIND_ADDR, BYTE_W'(col & 8'hFF), '0));
    pending_results.push_back(make_result(KIND_ADDR, BYTE_W'((col >> 8) & col_hi_mask), '0));
    pending_results.push_back(make_result(KIND_ADDR, BYTE_W'(row & 8'hFF), '0));
    pending_results.push_back(make_result(KIND_ADDR, BYTE_W'((row >> 8) & 8'hFF), '0));
    pending_results.push_back(make_result(KIND_ADDR, BYTE_W'((row >> 16) & 8'h01), '0));
    pending_results.push_back(make_result(KIND_CMD, CMD_CONFIRM, '0));
  endtask

  task automatic predict_page_read(input logic [ACT_W-1:0] act,
                                   input logic [CURSOR_W-1:0] addr,
                                   input logic [COUNT_W-1:0] len,
                                   input logic rdy,
                                   input logic [BYTE_W-1:0] fbyte);
    int prior_count;
    read_result_t tail;
    prior_count = pending_results.size();
    case (act)
      ACT_START: begin
        if (rd_phase == PH_IDLE) begin
          useful_requests++;
          rd_cursor = addr;
          rd_total = len;
          rd_done = '0;
          rd_column = addr % PAGE;
          pending_results.push_back(make_result(KIND_SELECT, '0, '0));
          if (len == '0) begin
            pending_results.push_back(make_result(KIND_DONE, '0, '0));
          end else begin
            push_address_burst();
            rd_phase = PH_WAIT;
          end
        end
      end
      ACT_STATUS: begin
        if (rd_phase == PH_WAIT && rdy) begin
          useful_requests++;
          rd_phase = PH_DATA;
        end
      end
      ACT_DATA: begin
        if (rd_phase == PH_DATA) begin
          useful_requests++;
          pending_results.push_back(make_result(KIND_DATA, fbyte, rd_done));
          rd_done = rd_done + 1'b1;
          rd_cursor = rd_cursor + 1'b1;
          rd_column++;
          if (rd_done == rd_total) begin
            pending_results.push_back(make_result(KIND_DONE, '0, '0));
            rd_phase = PH_IDLE;
          end else if (rd_column >= PAGE) begin
            rd_column = 0;
            push_address_burst();
            rd_phase = PH_WAIT;
          end
        end
      end
      default: ;
    endcase
    if (pending_results.size() > prior_count) begin
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endtask

  // entered and left at a falling edge
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic [CURSOR_W-1:0] addr,
                              input logic [COUNT_W-1:0] len,
                              input logic rdy,
                              input logic [BYTE_W-1:0] fbyte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_action = act;
    in_start_address = addr;
    in_length = len;
    in_ready_req = rdy;
    in_flash_byte = fbyte;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_page_read(act, addr, len, rdy, fbyte);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_tag != hold_tag_seen) begin
      hold_tag_seen = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d value %0h index %0d",
               out_kind, out_value, out_dest_index);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_kind !== head_result.kind) begin
          $error("out_kind: expected %0d, got %0d", head_result.kind, out_kind);
          fail_count++;
        end
        if (out_value !== head_result.value) begin
          $error("out_value: expected %0h, got %0h", head_result.value, out_value);
          fail_count++;
        end
        if (out_dest_index !== head_result.dest_index) begin
          $error("out_dest_index: expected %0d, got %0d",
                 head_result.dest_index, out_dest_index);
          fail_count++;
        end
        if (out_last !== head_result.last) begin
          $error("out_last: expected %0d, got %0d", head_result.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // no request moving on either side for too long means a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_zero_length();
    send_request(ACT_START, 28'h0000000, 24'h000000, 1'b0, 8'h00);
    send_request(ACT_START, 28'hFFFFFFF, 24'h000000, 1'b1, 8'hFF);
  endtask

  task automatic test_single_byte();
    send_request(ACT_START, 28'h0000000, 24'h000001, 1'b0, 8'h00);
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b0, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b0, 8'hFF);
  endtask

  task automatic test_ignored_items();
    // idle: everything but a start falls through
    send_request(ACT_UNUSED, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_START, 28'h1234567, 24'h000002, 1'b0, 8'h00);
    // waiting for ready
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b1, 8'hAA);
    send_request(ACT_START, 28'hFFFFFFF, 24'hFFFFFF, 1'b1, rand_byte());
    send_request(ACT_UNUSED, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    // receiving data
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_START, 28'h0000000, 24'h000000, 1'b0, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b0, 8'h01);
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b1, 8'h80);
  endtask

  task automatic test_page_crossing();
    // last two columns of the next-to-last page, third byte opens the last page
    send_request(ACT_START, 28'hFFFF7FE, 24'h000003, 1'b1, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b0, 8'h00);
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b0, 8'hA5);
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b0, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b1, 8'h5A);
  endtask

  task automatic test_random_reads(input int target);
    int first;
    logic [CURSOR_W-1:0] addr;
    logic [COUNT_W-1:0] len;
    logic [ACT_W-1:0] act;
    int pick;
    first = useful_requests;
    while (useful_requests - first < target) begin
      if ($urandom_range(99) < 10) begin
        act = ACT_W'($urandom_range(3));
        if (act == ACT_START) act = ACT_UNUSED;
        send_request(act, rand_addr(), rand_len(), rand_bit(), rand_byte());
      end
      addr = rand_addr();
      if ($urandom_range(99) < 40) begin
        addr = CURSOR_W'(addr - (addr % PAGE) + (PAGE - $urandom_range(1, 6)));
      end
      pick = $urandom_range(99);
      if (pick < 5) len = '0;
      else if (pick < 15) len = COUNT_W'($urandom_range(11, 40));
      else len = COUNT_W'($urandom_range(1, 10));
      send_request(ACT_START, addr, len, rand_bit(), rand_byte());
      while (rd_phase != PH_IDLE) begin
        if ($urandom_range(99) < 12) begin
          // stray request; a start only lands here while busy
          send_request(ACT_W'($urandom_range(3)), rand_addr(), rand_len(), rand_bit(),
                       rand_byte());
        end else if (rd_phase == PH_WAIT) begin
          send_request(ACT_STATUS, rand_addr(), rand_len(), ($urandom_range(99) >= 25),
                       rand_byte());
        end else begin
          send_request(ACT_DATA, rand_addr(), rand_len(), rand_bit(), rand_byte());
        end
      end
    end
  endtask

  task automatic test_output_stall();
    logic [CURSOR_W-1:0] addr;
    addr = rand_addr();
    addr = CURSOR_W'(addr - (addr % PAGE));
    hold_len = 80;
    hold_tag++;
    send_request(ACT_START, addr, 24'd30, 1'b0, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    while (rd_phase == PH_DATA) begin
      send_request(ACT_DATA, rand_addr(), rand_len(), rand_bit(), rand_byte());
    end
  endtask

  task automatic test_cursor_wrap();
    // longest length from the top address; left open in data phase at the end
    send_request(ACT_START, 28'hFFFFFFF, 24'hFFFFFF, 1'b0, rand_byte());
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b1, 8'hC3);
    send_request(ACT_STATUS, rand_addr(), rand_len(), 1'b1, rand_byte());
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b0, 8'h3C);
    send_request(ACT_DATA, rand_addr(), rand_len(), 1'b1, 8'hFF);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_START;
    in_start_address = '0;
    in_length = '0;
    in_ready_req = 1'b0;
    in_flash_byte = '0;
    out_ready = 1'b0;
    rd_phase = PH_IDLE;
    rd_cursor = '0;
    rd_done = '0;
    rd_total = '0;
    rd_column = 0;
    fail_count = 0;
    useful_requests = 0;
    hold_len = 0;
    hold_tag = 0;
    hold_tag_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 21;
    recv_idle_pct = 62;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_length();
    test_single_byte();
    test_ignored_items();
    test_page_crossing();
    test_random_reads(140);

    send_idle_pct = 62;
    recv_idle_pct = 21;
    test_random_reads(140);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_reads(110);
    test_cursor_wrap();

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
